>>> rtl/cmip_pkg.sv
`timescale 1ns / 1ps

package cmip_pkg;

	// One character of a CIGAR string, with string framing.
	typedef struct packed {
		logic [7:0]  code_char;
		logic        first_of_string;
		logic [31:0] start_position;
		logic        end_of_string;
	} item_t;

	// One reported result.
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] interval_begin;
		logic [31:0] interval_finish;
		logic        last_of_string;
	} result_t;

	localparam logic [1:0] KIND_MATCH = 2'd0;
	localparam logic [1:0] KIND_OK    = 2'd1;
	localparam logic [1:0] KIND_FAIL  = 2'd2;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_S    = 8'h53;

	localparam logic [31:0] RUN_MAX       = 32'hFFFF_FFFF;
	localparam logic [15:0] MIN_MATCH_RST = 16'd5;

endpackage

>>> rtl/cmip_result_fifo.sv
`timescale 1ns / 1ps

module cmip_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_count,
	input  cmip_pkg::result_t push_first,
	input  cmip_pkg::result_t push_second,
	output logic              room_two,
	output logic              out_valid,
	input  logic              out_ready,
	output cmip_pkg::result_t out_data
);

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	cmip_pkg::result_t entries_q [DEPTH];

	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] wr_next;
	logic [PTR_BITS:0]   count_q;
	logic                pop;

	assign wr_next   = wr_ptr_q + PTR_BITS'(1);
	assign out_valid = (count_q != '0);
	assign out_data  = entries_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	// Decided from the registered count alone, so it never waits on the output side.
	assign room_two  = (count_q <= (PTR_BITS+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entries_q[wr_ptr_q] <= push_first;
		end
		if (push_count == 2'd2) begin
			entries_q[wr_next] <= push_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + (PTR_BITS+1)'(push_count) - (PTR_BITS+1)'(pop);
		end
	end

endmodule

>>> rtl/cigar_match_interval_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Content
// item      sink       item_valid, item_ready, item         one CIGAR character
// result    source     result_valid, result_ready, result   interval or status
// cfg       sink       cfg_valid, cfg_ready, cfg_data       min_match_length
//
// Each character is decoded in the cycle it is taken and its results land in a
// four-entry result queue, so one character per cycle is sustained unless the queue backs up.
// A match that fails the length check yields two results, its interval and a failure.
// item_ready drops only while the queue has fewer than two free entries.
// Reset clears position and run length, arms the minimum at 5 and waits for a string start.

module cigar_match_interval_parser #(
	parameter int POSITION_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  cmip_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output cmip_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);

	localparam int WIDE = (POSITION_BITS > 32) ? POSITION_BITS : 32;

	logic [POSITION_BITS-1:0] pos_q;
	logic [31:0]              run_q;
	logic                     dead_q;
	logic [15:0]              min_q;

	logic                     accept;
	logic [WIDE-1:0]          start_wide;
	logic [WIDE-1:0]          run_wide;
	logic [WIDE-1:0]          pos_wide;
	logic [WIDE-1:0]          sum_wide;
	logic [POSITION_BITS-1:0] pos_base;
	logic [POSITION_BITS-1:0] pos_sum;
	logic [31:0]              run_base;
	logic                     dead_base;
	logic [35:0]              run_times_ten;
	logic [31:0]              run_digit;
	logic                     is_digit;

	logic [POSITION_BITS-1:0] pos_d;
	logic [31:0]              run_d;
	logic                     dead_d;
	logic [1:0]               push_count;
	cmip_pkg::result_t        res_first;
	cmip_pkg::result_t        res_second;
	logic                     room_two;

	assign item_ready = room_two;
	assign cfg_ready  = 1'b1;
	assign accept     = item_valid && item_ready;

	// A string start replaces the carried state before its character is decoded.
	assign start_wide = WIDE'(item.start_position);
	assign pos_base   = item.first_of_string ? start_wide[POSITION_BITS-1:0] : pos_q;
	assign run_base   = item.first_of_string ? 32'd0 : run_q;
	assign dead_base  = item.first_of_string ? 1'b0 : dead_q;

	assign run_wide = WIDE'(run_base);
	assign pos_sum  = pos_base + run_wide[POSITION_BITS-1:0];
	assign pos_wide = WIDE'(pos_base);
	assign sum_wide = WIDE'(pos_sum);

	assign is_digit      = (item.code_char >= cmip_pkg::CH_ZERO) &&
		(item.code_char <= cmip_pkg::CH_NINE);
	assign run_times_ten = (36'(run_base) << 3) + (36'(run_base) << 1) +
		36'(item.code_char - cmip_pkg::CH_ZERO);
	assign run_digit     = (run_times_ten[35:32] != 4'd0) ? cmip_pkg::RUN_MAX :
		run_times_ten[31:0];

	always_comb begin
		pos_d      = pos_base;
		run_d      = run_base;
		dead_d     = dead_base;
		push_count = 2'd0;
		res_first  = '0;
		res_second = '0;
		res_second.result_kind    = cmip_pkg::KIND_FAIL;
		res_second.last_of_string = 1'b1;
		if (!dead_base) begin
			if (item.end_of_string) begin
				res_first.result_kind    = cmip_pkg::KIND_OK;
				res_first.last_of_string = 1'b1;
				push_count = 2'd1;
				dead_d     = 1'b1;
				run_d      = 32'd0;
			end else begin
				case (item.code_char)
					cmip_pkg::CH_M: begin
						res_first.result_kind     = cmip_pkg::KIND_MATCH;
						res_first.interval_begin  = pos_wide[31:0];
						res_first.interval_finish = sum_wide[31:0];
						pos_d = pos_sum;
						run_d = 32'd0;
						if (run_base < 32'(min_q)) begin
							push_count = 2'd2;
							dead_d     = 1'b1;
						end else begin
							push_count = 2'd1;
						end
					end
					cmip_pkg::CH_N, cmip_pkg::CH_D: begin
						pos_d = pos_sum;
						run_d = 32'd0;
					end
					cmip_pkg::CH_I, cmip_pkg::CH_S: begin
						run_d = 32'd0;
					end
					default: begin
						if (is_digit) begin
							run_d = run_digit;
						end else begin
							res_first.result_kind    = cmip_pkg::KIND_FAIL;
							res_first.last_of_string = 1'b1;
							push_count = 2'd1;
							dead_d     = 1'b1;
							run_d      = 32'd0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			run_q  <= 32'd0;
			dead_q <= 1'b1;
			min_q  <= cmip_pkg::MIN_MATCH_RST;
		end else begin
			if (accept) begin
				pos_q  <= pos_d;
				run_q  <= run_d;
				dead_q <= dead_d;
			end
			if (cfg_valid && cfg_ready) begin
				min_q <= cfg_data;
			end
		end
	end

	cmip_result_fifo u_result_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_count  (accept ? push_count : 2'd0),
		.push_first  (res_first),
		.push_second (res_second),
		.room_two    (room_two),
		.out_valid   (result_valid),
		.out_ready   (result_ready),
		.out_data    (result)
	);

endmodule
